/* sv/ecpr_pkg.sv */
// ============================================================================
// ecpr_pkg
// Shared constants, types and codes for the enhanced clock replacement ring.
// ============================================================================
package ecpr_pkg;

    // Ring geometry
    localparam int RING_DEPTH = 16;
    localparam int PAGE_BITS  = 20;
    localparam int SLOT_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(RING_DEPTH + 1);
    localparam int SWAP_BITS  = PAGE_BITS + 1;

    typedef logic [PAGE_BITS-1:0]  page_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SWAP_BITS-1:0]  swap_t;
    typedef logic [1:0]            func_t;
    typedef logic [1:0]            kind_t;

    // Transaction function codes
    localparam func_t FUNC_INSERT    = 2'd0;
    localparam func_t FUNC_REFERENCE = 2'd1;
    localparam func_t FUNC_VICTIM    = 2'd2;

    // Result kind codes
    localparam kind_t KIND_ACCEPTED  = 2'd0;
    localparam kind_t KIND_WRITEBACK = 2'd1;
    localparam kind_t KIND_VICTIM    = 2'd2;
    localparam kind_t KIND_REJECTED  = 2'd3;

endpackage

/* sv/ecpr_ram.sv */
// ============================================================================
// ecpr_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ecpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/enhanced_clock_page_replacement.sv */
// ============================================================================
// enhanced_clock_page_replacement
// Enhanced second-chance clock ring: insert, reference and victim sweep over
// up to RING_DEPTH resident pages, with write-back reports for dirty pages.
// ============================================================================
//
//  Channel   Handshake       Payload
//  -------   -------------   ------------------------------------------------
//  request   start / busy    func, page_number, slot, is_write
//  result    strobe          kind, out_page, out_slot, swap_entry, last
//
//  A request transaction is taken on a clock edge with start high and busy
//  low. Insert and rejected requests answer in the next cycle and never
//  raise busy. A reference reads the page store, then answers from the
//  ST_REF state. A victim request visits one ring entry per cycle with the
//  shared next-hand unit, at most 2*entries+1 visits, and holds busy high
//  for the whole sweep. Each result is shown for one cycle under strobe;
//  the receiver cannot stall. Reset clears the ring bits, count, hand and
//  lock at once; the page store needs no clearing.
//
module enhanced_clock_page_replacement (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ecpr_pkg::func_t   func,
    input  ecpr_pkg::page_t   page_number,
    input  ecpr_pkg::slot_t   slot,
    input  logic              is_write,
    output logic              strobe,
    output ecpr_pkg::kind_t   kind,
    output ecpr_pkg::page_t   out_page,
    output ecpr_pkg::slot_t   out_slot,
    output ecpr_pkg::swap_t   swap_entry,
    output logic              last
);

    import ecpr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_REF   = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [RING_DEPTH-1:0] acc_reg, acc_next;
    logic [RING_DEPTH-1:0] dirty_reg, dirty_next;
    count_t                count_reg, count_next;
    slot_t                 hand_reg, hand_next;
    logic                  locked_reg, locked_next;
    slot_t                 freed_reg, freed_next;
    slot_t                 ref_slot_reg, ref_slot_next;

    logic                  strobe_reg, strobe_next;
    kind_t                 kind_reg, kind_next;
    page_t                 page_reg, page_next;
    slot_t                 oslot_reg, oslot_next;
    swap_t                 swap_reg, swap_next;
    logic                  last_reg, last_next;

    // Page store port signals
    logic   ram_we;
    slot_t  ram_waddr;
    page_t  ram_wdata;
    slot_t  ram_raddr;
    page_t  ram_rdata;

    // Hand arithmetic
    slot_t  hand_start;
    count_t hand_inc;
    slot_t  hand_adv;
    slot_t  ins_slot;

    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    ecpr_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (RING_DEPTH)
    ) u_page_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hand wrap: restart at zero when it points past the tail
    always_comb
    begin
        hand_start = (count_t'(hand_reg) >= count_reg) ? '0 : hand_reg;
        hand_inc   = count_t'(hand_reg) + count_t'(1);
        hand_adv   = (hand_inc >= count_reg) ? '0 : hand_inc[SLOT_BITS-1:0];
        ins_slot   = locked_reg ? freed_reg : count_reg[SLOT_BITS-1:0];
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        dirty_next    = dirty_reg;
        count_next    = count_reg;
        hand_next     = hand_reg;
        locked_next   = locked_reg;
        freed_next    = freed_reg;
        ref_slot_next = ref_slot_reg;

        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        page_next     = page_reg;
        oslot_next    = oslot_reg;
        swap_next     = swap_reg;
        last_next     = last_reg;

        ram_we        = 1'b0;
        ram_waddr     = ins_slot;
        ram_wdata     = page_number;
        ram_raddr     = hand_adv;

        case (state_reg)
            ST_IDLE:
            begin
                ram_raddr = (func == FUNC_REFERENCE) ? slot : hand_start;
                if (accept)
                begin
                    // Default answer: reject, single final result
                    strobe_next = 1'b1;
                    kind_next   = KIND_REJECTED;
                    page_next   = '0;
                    oslot_next  = '0;
                    swap_next   = '0;
                    last_next   = 1'b1;
                    case (func)
                        FUNC_INSERT:
                        begin
                            if (locked_reg || (count_reg < count_t'(RING_DEPTH)))
                            begin
                                ram_we              = 1'b1;
                                acc_next[ins_slot]  = 1'b1;
                                dirty_next[ins_slot] = is_write;
                                if (!locked_reg)
                                begin
                                    count_next = count_reg + count_t'(1);
                                end
                                kind_next  = KIND_ACCEPTED;
                                page_next  = page_number;
                                oslot_next = ins_slot;
                            end
                        end
                        FUNC_REFERENCE:
                        begin
                            if (count_t'(slot) < count_reg)
                            begin
                                acc_next[slot] = 1'b1;
                                if (is_write)
                                begin
                                    dirty_next[slot] = 1'b1;
                                end
                                ref_slot_next = slot;
                                strobe_next   = 1'b0;
                                state_next    = ST_REF;
                            end
                        end
                        FUNC_VICTIM:
                        begin
                            if (count_reg != '0)
                            begin
                                locked_next = 1'b1;
                                hand_next   = hand_start;
                                strobe_next = 1'b0;
                                state_next  = ST_SWEEP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_REF:
            begin
                strobe_next = 1'b1;
                kind_next   = KIND_ACCEPTED;
                page_next   = ram_rdata;
                oslot_next  = ref_slot_reg;
                swap_next   = '0;
                last_next   = 1'b1;
                state_next  = ST_IDLE;
            end

            ST_SWEEP:
            begin
                // Read data belongs to hand_reg; next entry is prefetched
                hand_next = hand_adv;
                if (acc_reg[hand_reg])
                begin
                    acc_next[hand_reg] = 1'b0;
                end
                else if (dirty_reg[hand_reg])
                begin
                    dirty_next[hand_reg] = 1'b0;
                    strobe_next = 1'b1;
                    kind_next   = KIND_WRITEBACK;
                    page_next   = ram_rdata;
                    oslot_next  = hand_reg;
                    swap_next   = swap_t'(ram_rdata) + swap_t'(1);
                    last_next   = 1'b0;
                end
                else
                begin
                    freed_next  = hand_reg;
                    strobe_next = 1'b1;
                    kind_next   = KIND_VICTIM;
                    page_next   = ram_rdata;
                    oslot_next  = hand_reg;
                    swap_next   = '0;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            acc_reg    <= '0;
            dirty_reg  <= '0;
            count_reg  <= '0;
            hand_reg   <= '0;
            locked_reg <= 1'b0;
            freed_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            dirty_reg  <= dirty_next;
            count_reg  <= count_next;
            hand_reg   <= hand_next;
            locked_reg <= locked_next;
            freed_reg  <= freed_next;
            strobe_reg <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ref_slot_reg <= ref_slot_next;
        kind_reg     <= kind_next;
        page_reg     <= page_next;
        oslot_reg    <= oslot_next;
        swap_reg     <= swap_next;
        last_reg     <= last_next;
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign out_page   = page_reg;
    assign out_slot   = oslot_reg;
    assign swap_entry = swap_reg;
    assign last       = last_reg;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the enhanced second-chance clock ring. A directed
// table covers the empty ring, unknown function code, ring fill up to and
// past full, out-of-range references and a first sweep with write-backs.
// Random inserts, references and victim sweeps then run on the locked ring.
// A local ring model predicts every result not typed into the table; results are checked in order.
// ============================================================================
module testbench;

    import ecpr_pkg::*;

    localparam func_t       FUNC_UNDEFINED = 2'd3;
    localparam int          DIRECTED_ROWS  = 25;
    localparam int          RANDOM_ITEMS   = 125;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          TAIL_CYCLES    = 2 * RING_DEPTH + 8;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    typedef struct packed {
        func_t func;
        page_t page;
        slot_t slot;
        logic  wr;
    } ring_request_t;

    typedef struct packed {
        kind_t kind;
        page_t page;
        slot_t slot;
        swap_t swap;
        logic  last;
    } ring_result_t;

    // Directed row: request plus an optional typed-in single result
    typedef struct packed {
        ring_request_t req;
        logic          typed;
        kind_t         kind;
        page_t         page;
        slot_t         slot;
    } table_row_t;

    logic  clk         = 1'b0;
    logic  rst_n       = 1'b0;
    logic  start       = 1'b0;
    func_t func        = FUNC_INSERT;
    page_t page_number = '0;
    slot_t slot        = '0;
    logic  is_write    = 1'b0;
    logic  busy;
    logic  strobe;
    kind_t kind;
    page_t out_page;
    slot_t out_slot;
    swap_t swap_entry;
    logic  last;

    enhanced_clock_page_replacement u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .page_number (page_number),
        .slot        (slot),
        .is_write    (is_write),
        .strobe      (strobe),
        .kind        (kind),
        .out_page    (out_page),
        .out_slot    (out_slot),
        .swap_entry  (swap_entry),
        .last        (last)
    );

    always #5 clk = ~clk;

    // Model copy of the ring
    page_t slot_pages    [RING_DEPTH];
    logic  slot_accessed [RING_DEPTH];
    logic  slot_dirty    [RING_DEPTH];
    int    resident_count = 0;
    int    hand_pos       = 0;
    logic  sweep_started  = 1'b0;
    int    refill_slot    = 0;

    ring_result_t step_results[$];
    ring_result_t pending_ring_results[$];

    int          error_count    = 0;
    int          results_seen   = 0;
    int          writebacks     = 0;
    int          victims        = 0;
    int          item_results   = 0;
    int          longest_answer = 0;
    int          func_seen[4]   = '{0, 0, 0, 0};
    int unsigned cycle_count    = 0;

    table_row_t directed_table [DIRECTED_ROWS] = '{
        // empty ring: victim, reference and unknown code all rejected
        '{'{FUNC_VICTIM,    20'h00000, 4'd0,  1'b0}, 1'b1, KIND_REJECTED, 20'h0, 4'd0},
        '{'{FUNC_REFERENCE, 20'h00000, 4'd0,  1'b0}, 1'b1, KIND_REJECTED, 20'h0, 4'd0},
        '{'{FUNC_UNDEFINED, 20'hFFFFF, 4'd15, 1'b1}, 1'b1, KIND_REJECTED, 20'h0, 4'd0},
        // first pages, page number extremes, both dirty
        '{'{FUNC_INSERT,    20'h00000, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h00000, 4'd0},
        '{'{FUNC_INSERT,    20'hFFFFF, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'hFFFFF, 4'd1},
        // reference beyond the resident count
        '{'{FUNC_REFERENCE, 20'h00000, 4'd15, 1'b1}, 1'b1, KIND_REJECTED, 20'h0, 4'd0},
        // fill the ring to full
        '{'{FUNC_INSERT,    20'h12345, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'h12345, 4'd2},
        '{'{FUNC_INSERT,    20'h80000, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h80000, 4'd3},
        '{'{FUNC_INSERT,    20'h7FFFF, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'h7FFFF, 4'd4},
        '{'{FUNC_INSERT,    20'h55555, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h55555, 4'd5},
        '{'{FUNC_INSERT,    20'hAAAAA, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'hAAAAA, 4'd6},
        '{'{FUNC_INSERT,    20'h00001, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h00001, 4'd7},
        '{'{FUNC_INSERT,    20'hFFFFE, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'hFFFFE, 4'd8},
        '{'{FUNC_INSERT,    20'h0F0F0, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h0F0F0, 4'd9},
        '{'{FUNC_INSERT,    20'hF0F0F, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'hF0F0F, 4'd10},
        '{'{FUNC_INSERT,    20'h33333, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h33333, 4'd11},
        '{'{FUNC_INSERT,    20'hCCCCC, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'hCCCCC, 4'd12},
        '{'{FUNC_INSERT,    20'h00400, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h00400, 4'd13},
        '{'{FUNC_INSERT,    20'hFFBFF, 4'd0,  1'b0}, 1'b1, KIND_ACCEPTED, 20'hFFBFF, 4'd14},
        '{'{FUNC_INSERT,    20'h9ABCD, 4'd0,  1'b1}, 1'b1, KIND_ACCEPTED, 20'h9ABCD, 4'd15},
        // full ring, not yet swept: insert rejected
        '{'{FUNC_INSERT,    20'hFFFFF, 4'd0,  1'b1}, 1'b1, KIND_REJECTED, 20'h0, 4'd0},
        // last slot reference, first sweep, then refill the freed slot twice
        '{'{FUNC_REFERENCE, 20'h00000, 4'd15, 1'b0}, 1'b0, KIND_ACCEPTED, 20'h0, 4'd0},
        '{'{FUNC_VICTIM,    20'h00000, 4'd0,  1'b0}, 1'b0, KIND_ACCEPTED, 20'h0, 4'd0},
        '{'{FUNC_INSERT,    20'h2468A, 4'd0,  1'b1}, 1'b0, KIND_ACCEPTED, 20'h0, 4'd0},
        '{'{FUNC_INSERT,    20'h13579, 4'd0,  1'b0}, 1'b0, KIND_ACCEPTED, 20'h0, 4'd0}
    };

    function automatic void add_ring_result(kind_t k, page_t p, slot_t s, swap_t w,
                                            logic l);
        ring_result_t r;
        r = '{kind: k, page: p, slot: s, swap: w, last: l};
        step_results.push_back(r);
    endfunction

    // Ring model: apply one transaction, leave its results in step_results
    function automatic void clock_ring_step(ring_request_t req);
        int s;
        int visit;
        step_results.delete();
        case (req.func)
            FUNC_INSERT:
            begin
                if (sweep_started) begin
                    s = refill_slot;
                end else if (resident_count < RING_DEPTH) begin
                    s = resident_count;
                    resident_count++;
                end else begin
                    add_ring_result(KIND_REJECTED, '0, '0, '0, 1'b1);
                    return;
                end
                slot_pages[s]    = req.page;
                slot_accessed[s] = 1'b1;
                slot_dirty[s]    = req.wr;
                add_ring_result(KIND_ACCEPTED, req.page, slot_t'(s), '0, 1'b1);
            end
            FUNC_REFERENCE:
            begin
                s = int'(req.slot);
                if (s >= resident_count) begin
                    add_ring_result(KIND_REJECTED, '0, '0, '0, 1'b1);
                end else begin
                    slot_accessed[s] = 1'b1;
                    if (req.wr)
                        slot_dirty[s] = 1'b1;
                    add_ring_result(KIND_ACCEPTED, slot_pages[s], slot_t'(s), '0, 1'b1);
                end
            end
            FUNC_VICTIM:
            begin
                if (resident_count == 0) begin
                    add_ring_result(KIND_REJECTED, '0, '0, '0, 1'b1);
                    return;
                end
                sweep_started = 1'b1;
                if (hand_pos >= resident_count)
                    hand_pos = 0;
                for (visit = 0; visit < 3 * RING_DEPTH + 1; visit++) begin
                    s = hand_pos;
                    hand_pos = (s + 1 >= resident_count) ? 0 : s + 1;
                    if (slot_accessed[s]) begin
                        slot_accessed[s] = 1'b0;
                    end else if (slot_dirty[s]) begin
                        add_ring_result(KIND_WRITEBACK, slot_pages[s], slot_t'(s),
                                        swap_t'(slot_pages[s]) + swap_t'(1), 1'b0);
                        slot_dirty[s] = 1'b0;
                    end else begin
                        refill_slot = s;
                        add_ring_result(KIND_VICTIM, slot_pages[s], slot_t'(s), '0, 1'b1);
                        return;
                    end
                end
                // every entry is clean and unaccessed by the third pass
                add_ring_result(KIND_REJECTED, '0, '0, '0, 1'b1);
            end
            default:
            begin
                add_ring_result(KIND_REJECTED, '0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    // Drive one transaction, wait for acceptance, queue its predicted results
    task automatic issue_request(ring_request_t req, logic typed, ring_result_t typed_result);
        start       <= 1'b1;
        func        <= req.func;
        page_number <= req.page;
        slot        <= req.slot;
        is_write    <= req.wr;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        clock_ring_step(req);
        if (typed) begin
            step_results.delete();
            step_results.push_back(typed_result);
        end
        foreach (step_results[i])
            pending_ring_results.push_back(step_results[i]);
        func_seen[req.func]++;
    endtask

    // Hold start low until every queued result has come out
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_ring_results.size() != 0);
    endtask

    // Sender pacing: bursts of random length, random gaps, occasional drain
    int burst_left = 1;

    task automatic pace_sender();
        int gap;
        burst_left--;
        if (burst_left > 0)
            return;
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                 : $urandom_range(1, 8);
        if ($urandom_range(0, 5) == 0) begin
            drain_results();
        end else if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin : stimulus
        ring_request_t req;
        ring_result_t  typed_result;
        int            row;
        int            sent;
        int            pick;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_ROWS; row++) begin
            typed_result = '{kind: directed_table[row].kind, page: directed_table[row].page,
                             slot: directed_table[row].slot, swap: '0, last: 1'b1};
            issue_request(directed_table[row].req, directed_table[row].typed, typed_result);
            pace_sender();
        end
        drain_results();

        // Random traffic on the locked ring; unknown codes do not count
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                req.func = FUNC_INSERT;
            else if (pick < 70)
                req.func = FUNC_REFERENCE;
            else if (pick < 96)
                req.func = FUNC_VICTIM;
            else
                req.func = FUNC_UNDEFINED;
            case ($urandom_range(0, 7))
                0:       req.page = '0;
                1:       req.page = '1;
                default: req.page = page_t'($urandom());
            endcase
            req.slot = slot_t'($urandom_range(0, RING_DEPTH - 1));
            req.wr   = 1'($urandom_range(0, 1));
            issue_request(req, 1'b0, '0);
            if (req.func != FUNC_UNDEFINED)
                sent++;
            pace_sender();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("summary: %0d inserts, %0d references, %0d victim requests, %0d unknown codes",
                 func_seen[FUNC_INSERT], func_seen[FUNC_REFERENCE], func_seen[FUNC_VICTIM],
                 func_seen[FUNC_UNDEFINED]);
        $display("summary: %0d results checked, %0d write-backs, %0d victims, longest answer %0d",
                 results_seen, writebacks, victims, longest_answer);
        if (error_count == 0 && pending_ring_results.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    // Result checker
    always @(posedge clk)
    begin
        ring_result_t exp;
        logic         bad;
        if (rst_n === 1'b1 && strobe === 1'b1) begin
            results_seen++;
            item_results++;
            if (last === 1'b1) begin
                if (item_results > longest_answer)
                    longest_answer = item_results;
                item_results = 0;
            end
            if (kind === KIND_WRITEBACK)
                writebacks++;
            if (kind === KIND_VICTIM)
                victims++;
            if (pending_ring_results.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("ERROR %0t: result with no transaction pending: kind %0d page %h",
                             $realtime, kind, out_page);
            end else begin
                exp = pending_ring_results.pop_front();
                bad = (kind !== exp.kind) || (out_page !== exp.page) ||
                      (out_slot !== exp.slot) || (swap_entry !== exp.swap) ||
                      (last !== exp.last);
                if (bad) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"ERROR %0t: expected kind %0d page %h slot %0d swap %h last %b,",
                                  " got kind %0d page %h slot %0d swap %h last %b"},
                                 $realtime, exp.kind, exp.page, exp.slot, exp.swap, exp.last,
                                 kind, out_page, out_slot, swap_entry, last);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_ring_results.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

endmodule

/* sim.f */
sv/ecpr_pkg.sv
sv/ecpr_ram.sv
sv/enhanced_clock_page_replacement.sv
test/testbench.sv
